### design/tlc_pkg.sv
package tlc_pkg;

    localparam int RAW_W          = 16;
    localparam int MAG_W          = 15;
    localparam int MC_W           = 18;
    localparam int TENTHS_W       = 12;
    localparam int DEG_W          = 8;
    localparam int LEVEL_W        = 2;
    localparam int THR_W          = 12;
    localparam int BAND_W         = 8;
    localparam int THRESHOLD_REGS = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = THR_W;

    // millidegrees = mag * 1000 / 128, tenths = mag * 10 / 128, degrees = mag / 128
    localparam int MC_SCALE     = 1000;
    localparam int TENTHS_SCALE = 10;
    localparam int FRAC_SHIFT   = 7;
    localparam int MC_PROD_W    = MAG_W + 10;
    localparam int TENTHS_PROD_W = MAG_W + 4;

    localparam logic [THR_W-1:0]  THR0_RST = 12'd0;
    localparam logic [THR_W-1:0]  THR1_RST = 12'd560;
    localparam logic [THR_W-1:0]  THR2_RST = 12'd600;
    localparam logic [THR_W-1:0]  THR3_RST = 12'd670;
    localparam logic [BAND_W-1:0] BAND_RST = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR0 = 3'd0,
        CFG_THR1 = 3'd1,
        CFG_THR2 = 3'd2,
        CFG_THR3 = 3'd3,
        CFG_BAND = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [THRESHOLD_REGS-1:0][THR_W-1:0] thr;
        logic [BAND_W-1:0]                    band;
    } t_cfg;

endpackage

### design/tlc_if.sv
interface tlc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [tlc_pkg::RAW_W-1:0]   raw_sample;
    logic                               read_failed;

    modport source (output valid, output raw_sample, output read_failed, input ready);
    modport sink   (input valid, input raw_sample, input read_failed, output ready);
endinterface

interface tlc_out_if;
    logic                               valid;
    logic                               ready;
    logic [tlc_pkg::MC_W-1:0]           temp_millidegrees;
    logic [tlc_pkg::TENTHS_W-1:0]       temp_tenths;
    logic [tlc_pkg::LEVEL_W-1:0]        throttle_level;

    modport source (output valid, output temp_millidegrees, output temp_tenths,
                    output throttle_level, input ready);
    modport sink   (input valid, input temp_millidegrees, input temp_tenths,
                    input throttle_level, output ready);
endinterface

interface tlc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tlc_pkg::CFG_IDX_W-1:0]      index;
    logic [tlc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/tlc_cfg_regs.sv
module tlc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_valid,
    output logic                           o_wr_ready,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0] i_wr_data,
    output tlc_pkg::t_cfg                  o_cfg
);
    import tlc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_THR0: n_cfg.thr[0] = i_wr_data[THR_W-1:0];
                CFG_THR1: n_cfg.thr[1] = i_wr_data[THR_W-1:0];
                CFG_THR2: n_cfg.thr[2] = i_wr_data[THR_W-1:0];
                CFG_THR3: n_cfg.thr[3] = i_wr_data[THR_W-1:0];
                CFG_BAND: n_cfg.band   = i_wr_data[BAND_W-1:0];
                default:  n_cfg       = r_cfg;   // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr[0] <= THR0_RST;
            r_cfg.thr[1] <= THR1_RST;
            r_cfg.thr[2] <= THR2_RST;
            r_cfg.thr[3] <= THR3_RST;
            r_cfg.band   <= BAND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### design/tlc_level.sv
module tlc_level #(
    parameter int LEVEL_COUNT = 4
) (
    input  logic [tlc_pkg::TENTHS_W-1:0] i_tenths,
    input  logic                         i_rising,
    input  tlc_pkg::t_cfg                i_cfg,
    output logic [tlc_pkg::LEVEL_W-1:0]  o_level
);
    import tlc_pkg::*;

    localparam int USED = (LEVEL_COUNT < THRESHOLD_REGS) ? LEVEL_COUNT : THRESHOLD_REGS;
    localparam int CMP_W = THR_W + 2;

    logic signed [CMP_W-1:0] band_s;
    logic signed [CMP_W-1:0] tenths_s;

    assign band_s   = i_rising ? '0 : $signed({{(CMP_W-BAND_W){1'b0}}, i_cfg.band});
    assign tenths_s = $signed({{(CMP_W-TENTHS_W){1'b0}}, i_tenths});

    // highest-indexed met threshold wins; when not rising, a threshold below the band is always met
    always_comb begin
        logic signed [CMP_W-1:0] limit;
        limit   = '0;
        o_level = '0;
        for (int i = 0; i < USED; i++) begin
            limit = $signed({{(CMP_W-THR_W){1'b0}}, i_cfg.thr[i]}) - band_s;
            if (tenths_s >= limit) begin
                o_level = LEVEL_W'(i);
            end
        end
    end

endmodule

### design/tlc_datapath.sv
module tlc_datapath #(
    parameter int LEVEL_COUNT = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tlc_pkg::t_cfg                    i_cfg,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [tlc_pkg::RAW_W-1:0] i_raw_sample,
    input  logic                             i_read_failed,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tlc_pkg::MC_W-1:0]         o_temp_millidegrees,
    output logic [tlc_pkg::TENTHS_W-1:0]     o_temp_tenths,
    output logic [tlc_pkg::LEVEL_W-1:0]      o_throttle_level
);
    import tlc_pkg::*;

    // input stage
    logic                     r_in_valid;
    logic signed [RAW_W-1:0]  r_in_raw;
    logic                     r_in_failed;

    // state: last sample magnitude and last reported value
    logic [MAG_W-1:0]         r_last_mag;
    logic [DEG_W-1:0]         r_rep_deg;
    logic [TENTHS_W-1:0]      r_rep_tenths;

    // result stage
    logic                     r_out_valid;
    logic [MC_W-1:0]          r_out_mc;
    logic [TENTHS_W-1:0]      r_out_tenths;
    logic [LEVEL_W-1:0]       r_out_level;

    logic [MAG_W-1:0]         n_mag;
    logic [MAG_W-1:0]         cur_mag;
    logic [MC_PROD_W-1:0]     mc_prod;
    logic [TENTHS_PROD_W-1:0] tenths_prod;
    logic [MC_W-1:0]          cur_mc;
    logic [TENTHS_W-1:0]      cur_tenths;
    logic [DEG_W-1:0]         cur_deg;
    logic                     emit;
    logic                     rising;
    logic [LEVEL_W-1:0]       level;
    logic                     out_free;
    logic                     stage_done;
    logic                     in_fire;

    // clear the mode bit; a negative reading clamps to zero
    assign n_mag = r_in_raw[RAW_W-1] ? '0 : {r_in_raw[MAG_W-1:1], 1'b0};
    assign cur_mag = r_in_failed ? r_last_mag : n_mag;

    assign mc_prod     = MC_PROD_W'(cur_mag) * MC_PROD_W'(MC_SCALE);
    assign tenths_prod = TENTHS_PROD_W'(cur_mag) * TENTHS_PROD_W'(TENTHS_SCALE);
    assign cur_mc      = mc_prod[FRAC_SHIFT +: MC_W];
    assign cur_tenths  = tenths_prod[FRAC_SHIFT +: TENTHS_W];
    assign cur_deg     = cur_mag[FRAC_SHIFT +: DEG_W];

    assign emit   = (cur_deg != r_rep_deg);
    assign rising = (cur_tenths > r_rep_tenths);

    tlc_level #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_level (
        .i_tenths (cur_tenths),
        .i_rising (rising),
        .i_cfg    (i_cfg),
        .o_level  (level)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign stage_done = r_in_valid && (!emit || out_free);
    assign o_in_ready = !r_in_valid || stage_done;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (stage_done) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_raw    <= i_raw_sample;
            r_in_failed <= i_read_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mag   <= '0;
            r_rep_deg    <= '0;
            r_rep_tenths <= '0;
        end else if (stage_done) begin
            r_last_mag <= cur_mag;
            if (emit) begin
                r_rep_deg    <= cur_deg;
                r_rep_tenths <= cur_tenths;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_done && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_done && emit) begin
            r_out_mc     <= cur_mc;
            r_out_tenths <= cur_tenths;
            r_out_level  <= level;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_temp_millidegrees = r_out_mc;
    assign o_temp_tenths       = r_out_tenths;
    assign o_throttle_level    = r_out_level;

endmodule

### design/thermal_level_classifier.sv
// A result comes from its sample transaction through the input register, then the
//   result register; a sample that repeats the reported whole degree yields none.
// Throughput: one sample per cycle while the output is not stalled; the result register and input register each
//   take a new item in the cycle the downstream side drains them.
// Reset (synchronous, active low): thresholds 0/560/600/670, band 30, stored
//   reading and reported temperature zero, both pipeline stages empty.
module thermal_level_classifier #(
    parameter int LEVEL_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlc_in_if.sink     i_in,
    tlc_out_if.source  o_out,
    tlc_cfg_if.sink    i_cfg
);
    import tlc_pkg::*;

    t_cfg cfg;

    tlc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    tlc_datapath #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_in_valid          (i_in.valid),
        .o_in_ready          (i_in.ready),
        .i_raw_sample        (i_in.raw_sample),
        .i_read_failed       (i_in.read_failed),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_temp_millidegrees (o_out.temp_millidegrees),
        .o_temp_tenths       (o_out.temp_tenths),
        .o_throttle_level    (o_out.throttle_level)
    );

endmodule

### design/tlc_checker.sv
module tlc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [tlc_pkg::MC_W-1:0]     i_temp_millidegrees,
    input  logic [tlc_pkg::TENTHS_W-1:0] i_temp_tenths,
    input  logic [tlc_pkg::LEVEL_W-1:0]  i_throttle_level
);
    import tlc_pkg::*;

    logic                in_fire;
    logic                out_fire;
    logic [TENTHS_W-1:0] r_last_tenths;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // track the tenths of the last delivered transaction; reset value matches zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tenths <= '0;
        end else if (out_fire) begin
            r_last_tenths <= i_temp_tenths;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_result_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_fire, 2))
        else $error("result appeared without a sample two cycles earlier");

    a_new_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> (i_temp_tenths != r_last_tenths))
        else $error("result repeats the previously reported temperature");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_temp_millidegrees) && $stable(i_temp_tenths)
             && $stable(i_throttle_level)))
        else $error("stalled result changed");

endmodule

bind thermal_level_classifier tlc_checker u_tlc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_temp_millidegrees (o_out.temp_millidegrees),
    .i_temp_tenths       (o_out.temp_tenths),
    .i_throttle_level    (o_out.throttle_level)
);

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    localparam int LEVEL_COUNT  = 4;
    localparam int MAX_TENTHS   = 2559;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 400;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [MC_W-1:0]     millideg;
        logic [TENTHS_W-1:0] tenths;
        logic [LEVEL_W-1:0]  level;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlc_in_if  in_if ();
    tlc_out_if out_if ();
    tlc_cfg_if cfg_if ();

    thermal_level_classifier #(
        .LEVEL_COUNT(LEVEL_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the block's registers and stored readings
    logic [THR_W-1:0]  thr_shadow [THRESHOLD_REGS];
    logic [BAND_W-1:0] band_shadow;
    logic [MC_W-1:0]   stored_mc;
    logic [MC_W-1:0]   reported_mc;

    t_reading expected_readings [$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    int       walk_tenths = 0;
    int       stall_left = 0;
    bit       full_rate = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.raw_sample  = '0;
        in_if.read_failed = 1'b0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_THR0;
        cfg_if.data       = '0;
    end

    function automatic void reset_shadow();
        thr_shadow[CFG_THR0] = THR0_RST;
        thr_shadow[CFG_THR1] = THR1_RST;
        thr_shadow[CFG_THR2] = THR2_RST;
        thr_shadow[CFG_THR3] = THR3_RST;
        band_shadow = BAND_RST;
        stored_mc   = '0;
        reported_mc = '0;
    endfunction

    // Work out the reading (if any) that one accepted sample produces
    function automatic void classify_sample(logic [RAW_W-1:0] raw, logic failed);
        int       mag;
        int       bar;
        int       lvl;
        bit       rising;
        t_reading r;
        if (!failed) begin
            if (raw[RAW_W-1]) begin
                stored_mc = '0;
            end else begin
                mag = int'({raw[MAG_W-1:1], 1'b0});
                stored_mc = MC_W'((mag * MC_SCALE) >> FRAC_SHIFT);
            end
        end
        if (stored_mc / MC_SCALE == reported_mc / MC_SCALE)
            return;
        r.millideg = stored_mc;
        r.tenths   = TENTHS_W'(stored_mc / 100);
        rising     = r.tenths > reported_mc / 100;
        lvl = 0;
        for (int i = 0; i < LEVEL_COUNT && i < THRESHOLD_REGS; i++) begin
            bar = int'(thr_shadow[i]) - (rising ? 0 : int'(band_shadow));
            if (int'(r.tenths) >= bar)
                lvl = i;
        end
        r.level = LEVEL_W'(lvl);
        expected_readings.push_back(r);
        reported_mc = stored_mc;
    endfunction

    function automatic int clamp_tenths(int tenths);
        if (tenths < 0)
            return 0;
        if (tenths > MAX_TENTHS)
            return MAX_TENTHS;
        return tenths;
    endfunction

    // Smallest even register code at or above the given tenths; bit 0 random
    function automatic logic [RAW_W-1:0] raw_for_tenths(int tenths);
        int code;
        code = ((tenths * (1 << FRAC_SHIFT) + TENTHS_SCALE - 1) / TENTHS_SCALE + 1) & ~1;
        return RAW_W'(code | int'($urandom_range(0, 1)));
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task automatic push_sample(logic [RAW_W-1:0] raw, logic failed);
        @(negedge i_clk);
        if (!full_rate && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_sample  <= raw;
        in_if.read_failed <= failed;
        do @(posedge i_clk); while (!in_if.ready);
        classify_sample(raw, failed);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < THRESHOLD_REGS)
            thr_shadow[idx] = value;
        else if (idx == CFG_BAND)
            band_shadow = value[BAND_W-1:0];
    endtask

    // Band word carries junk above the band width; a write to an unused index follows
    task automatic apply_settings(t_cfg setting, logic [CFG_DATA_W-BAND_W-1:0] band_top);
        logic [CFG_IDX_W-1:0] spare_idx;
        spare_idx = CFG_IDX_W'($urandom_range(int'(CFG_BAND) + 1, (1 << CFG_IDX_W) - 1));
        wait_idle();
        write_register(CFG_THR0, setting.thr[CFG_THR0]);
        write_register(CFG_THR1, setting.thr[CFG_THR1]);
        write_register(CFG_THR2, setting.thr[CFG_THR2]);
        write_register(CFG_THR3, setting.thr[CFG_THR3]);
        write_register(CFG_BAND, {band_top, setting.band});
        write_register(spare_idx, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_samples(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                walk_tenths = clamp_tenths(walk_tenths + int'($urandom_range(0, 240)) - 120);
                push_sample(raw_for_tenths(walk_tenths), 1'b0);
            end else if (pick < 75) begin
                walk_tenths = clamp_tenths(int'(thr_shadow[$urandom_range(0, THRESHOLD_REGS - 1)])
                                           + int'($urandom_range(0, 80)) - 40);
                push_sample(raw_for_tenths(walk_tenths), 1'b0);
            end else if (pick < 87) begin
                push_sample(RAW_W'($urandom), 1'b0);
            end else if (pick < 95) begin
                push_sample(RAW_W'($urandom), 1'b1);
            end else begin
                push_sample({1'b1, (RAW_W-1)'($urandom)}, 1'b0);
            end
        end
    endtask

    task automatic test_conversion_extremes();
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h7FFE, 1'b0);
        push_sample(16'h1234, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0100, 1'b0);
        push_sample(16'h7FFF, 1'b1);
    endtask

    // Climb through every threshold, then fall back inside and below the hysteresis band
    task automatic test_threshold_levels();
        int path [10] = '{530, 545, 565, 605, 675, 650, 635, 595, 560, 525};
        foreach (path[k])
            push_sample(raw_for_tenths(path[k]), 1'b0);
    endtask

    task automatic test_band_over_thresholds();
        t_cfg setting;
        setting.thr[CFG_THR0] = '1;
        setting.thr[CFG_THR1] = THR_W'(10);
        setting.thr[CFG_THR2] = '1;
        setting.thr[CFG_THR3] = '0;
        setting.band          = '1;
        apply_settings(setting, '1);
        push_sample(raw_for_tenths(1000), 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(raw_for_tenths(20), 1'b0);
    endtask

    task automatic test_random_settings();
        t_cfg setting;
        int   acc;
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < THRESHOLD_REGS; i++)
                setting.thr[i] = THR_W'($urandom_range(0, 2700));
            setting.band = BAND_W'($urandom);
            case (p)
                0: begin
                    setting = '0;
                end
                1: begin
                    setting = '1;
                end
                2: begin
                    setting.thr[CFG_THR0] = THR0_RST;
                    setting.thr[CFG_THR1] = THR1_RST;
                    setting.thr[CFG_THR2] = THR2_RST;
                    setting.thr[CFG_THR3] = THR3_RST;
                    setting.band          = BAND_RST;
                end
                3, 4: begin
                    acc = 0;
                    for (int i = 0; i < THRESHOLD_REGS; i++) begin
                        acc += $urandom_range(0, 700);
                        setting.thr[i] = THR_W'(acc);
                    end
                end
                default: begin
                end
            endcase
            apply_settings(setting, (p == 1) ? '1 : (CFG_DATA_W-BAND_W)'($urandom));
            random_samples(120);
        end
    endtask

    task automatic test_full_rate();
        t_cfg setting;
        for (int i = 0; i < THRESHOLD_REGS; i++)
            setting.thr[i] = THR_W'($urandom_range(200, 1200));
        setting.band = BAND_W'($urandom_range(0, 60));
        apply_settings(setting, '0);
        full_rate = 1'b1;
        random_samples(120);
    endtask

    // Output side: random stall bursts until the full-rate part
    always @(negedge i_clk) begin
        if (full_rate) begin
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            out_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected reading %0d mC", out_if.temp_millidegrees));
            end else begin
                want = expected_readings.pop_front();
                if (out_if.temp_millidegrees !== want.millideg)
                    report_mismatch($sformatf("temp_millidegrees got %0d, want %0d",
                                              out_if.temp_millidegrees, want.millideg));
                if (out_if.temp_tenths !== want.tenths)
                    report_mismatch($sformatf("temp_tenths got %0d, want %0d",
                                              out_if.temp_tenths, want.tenths));
                if (out_if.throttle_level !== want.level)
                    report_mismatch($sformatf("throttle_level got %0d, want %0d (%0d mC)",
                                              out_if.throttle_level, want.level, want.millideg));
            end
        end
    end

    // Abort when no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        reset_shadow();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_conversion_extremes();
        test_threshold_levels();
        test_band_over_thresholds();
        test_random_settings();
        test_full_rate();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
design/tlc_pkg.sv
design/tlc_if.sv
design/tlc_cfg_regs.sv
design/tlc_level.sv
design/tlc_datapath.sv
design/thermal_level_classifier.sv
design/tlc_checker.sv
bench/testbench.sv
